// ----- design/pdcp_cst_pkg.sv -----
// Shared types, codes and helpers for the PDCP COUNT / sequence tracker.
// No dependencies; the front end, back end and top level import this package.
package pdcp_cst_pkg;

	// Field widths
	localparam int NUM_W   = 18;
	localparam int HFN_W   = 27;
	localparam int COUNT_W = 32;
	localparam int LEN_W   = 5;
	localparam int WIN_W   = 12;
	localparam int BYTES_W = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 12;

	// Default queue depths
	localparam int CMD_DEPTH_DEF = 4;
	localparam int RES_DEPTH_DEF = 2;

	// Opcodes
	localparam logic [1:0] OP_TX    = 2'd0;
	localparam logic [1:0] OP_RX    = 2'd1;
	localparam logic [1:0] OP_REEST = 2'd2;

	// Bearer modes
	localparam logic [1:0] MODE_SRB = 2'd0;
	localparam logic [1:0] MODE_UM  = 2'd1;

	// Result status codes
	localparam logic [2:0] ST_TX_ASSIGNED = 3'd0;
	localparam logic [2:0] ST_RX_DELIVER  = 3'd1;
	localparam logic [2:0] ST_RX_DISCARD  = 3'd2;
	localparam logic [2:0] ST_RX_SHORT    = 3'd3;
	localparam logic [2:0] ST_CTRL_PASSED = 3'd4;
	localparam logic [2:0] ST_TX_DROPPED  = 3'd5;
	localparam logic [2:0] ST_INTEG_FAIL  = 3'd6;
	localparam logic [2:0] ST_REESTAB     = 3'd7;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SN_LENGTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BEARER_MODE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_REORDER_WINDOW = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES   = 2'd3;

	// Reset values
	localparam logic [LEN_W-1:0] SN_LENGTH_RST      = 5'd12;
	localparam logic [1:0]       BEARER_MODE_RST    = 2'd2;
	localparam logic [WIN_W-1:0] REORDER_WINDOW_RST = 12'd2048;
	localparam logic [1:0]       HEADER_BYTES_RST   = 2'd2;
	localparam logic [NUM_W-1:0] LAST_DELIV_RST     = 18'd4095;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [NUM_W-1:0]   seq_num;
		logic               use_given_num;
		logic               lower_queue_full;
		logic               is_control;
		logic [BYTES_W-1:0] pdu_bytes;
		logic               integrity_passed;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [COUNT_W-1:0] count_value;
		logic [NUM_W-1:0]   used_num;
	} out_item_t;

	typedef struct packed {
		logic [LEN_W-1:0] sn_length;
		logic [1:0]       bearer_mode;
		logic [WIN_W-1:0] reorder_window;
		logic [1:0]       header_bytes;
	} cfg_t;

	// Item classes decided by the front end
	typedef enum logic [3:0] {
		K_TX_DROP,
		K_TX_GIVEN,
		K_TX_NEXT,
		K_RX_CTRL,
		K_RX_SHORT,
		K_RX_SRB,
		K_RX_UM,
		K_RX_AM,
		K_REEST_CLR,
		K_REEST_KEEP
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [NUM_W-1:0] sn;
		logic             integ_ok;
	} cls_item_t;

	// Clamp the configured number width to 5..18
	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
		logic [LEN_W-1:0] r;
		if (len < LEN_W'(5)) begin
			r = LEN_W'(5);
		end else if (len > LEN_W'(NUM_W)) begin
			r = LEN_W'(NUM_W);
		end else begin
			r = len;
		end
		return r;
	endfunction

	// Largest sequence number for a clamped width
	function automatic logic [NUM_W-1:0] num_mask(input logic [LEN_W-1:0] len);
		logic [NUM_W-1:0] ones;
		ones = '1;
		return ~(ones << len);
	endfunction

endpackage

// ----- design/pdcp_cst_queue.sv -----
// Small register queue used between front and back end and for results.
// Depends on nothing; width and depth come in as parameters (depth >= 2).
module pdcp_cst_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// ----- design/pdcp_cst_front.sv -----
// Front end: accepts input items, classifies them and masks the number.
// Depends on pdcp_cst_pkg; feeds the command queue.
module pdcp_cst_front (
	input  pdcp_cst_pkg::cfg_t      cfg,
	input  logic                    push,
	input  pdcp_cst_pkg::in_item_t  in_item,
	output logic                    full,
	output logic                    cls_push,
	output pdcp_cst_pkg::cls_item_t cls_item,
	input  logic                    cls_full
);
	import pdcp_cst_pkg::*;

	logic [LEN_W-1:0] len;
	logic             is_data;
	logic             op_valid;

	assign len      = eff_len(cfg.sn_length);
	assign is_data  = (cfg.bearer_mode != MODE_SRB);
	assign op_valid = (in_item.opcode == OP_TX) || (in_item.opcode == OP_RX) ||
	                  (in_item.opcode == OP_REEST);
	assign full     = cls_full;
	// Drop the unused opcode here: it is taken but never queued
	assign cls_push = push && !cls_full && op_valid;

	// Classify the transaction
	always_comb begin
		cls_item.sn       = in_item.seq_num & num_mask(len);
		cls_item.integ_ok = in_item.integrity_passed;
		cls_item.kind     = K_REEST_KEEP;
		case (in_item.opcode)
			OP_TX: begin
				if (in_item.lower_queue_full) begin
					cls_item.kind = K_TX_DROP;
				end else if (in_item.use_given_num) begin
					cls_item.kind = K_TX_GIVEN;
				end else begin
					cls_item.kind = K_TX_NEXT;
				end
			end
			OP_RX: begin
				if (is_data && in_item.is_control) begin
					cls_item.kind = K_RX_CTRL;
				end else if (in_item.pdu_bytes <= BYTES_W'(cfg.header_bytes)) begin
					cls_item.kind = K_RX_SHORT;
				end else if (cfg.bearer_mode == MODE_SRB) begin
					cls_item.kind = K_RX_SRB;
				end else if (cfg.bearer_mode == MODE_UM) begin
					cls_item.kind = K_RX_UM;
				end else begin
					cls_item.kind = K_RX_AM;
				end
			end
			OP_REEST: begin
				if (cfg.bearer_mode == MODE_SRB || cfg.bearer_mode == MODE_UM) begin
					cls_item.kind = K_REEST_CLR;
				end else begin
					cls_item.kind = K_REEST_KEEP;
				end
			end
			default: begin
				cls_item.kind = K_REEST_KEEP;
			end
		endcase
	end

endmodule

// ----- design/pdcp_cst_back.sv -----
// Back end: holds the bearer's counters, estimates COUNT and forms results.
// Depends on pdcp_cst_pkg; reads the command queue, writes the result queue.
module pdcp_cst_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pdcp_cst_pkg::cfg_t      cfg,
	input  logic                    cmd_valid,
	input  pdcp_cst_pkg::cls_item_t cmd_item,
	output logic                    cmd_pop,
	output logic                    res_push,
	output pdcp_cst_pkg::out_item_t res_item,
	input  logic                    res_full
);
	import pdcp_cst_pkg::*;

	logic [NUM_W-1:0] next_tx_q, next_rx_q, last_q;
	logic [HFN_W-1:0] tx_hfn_q, rx_hfn_q;
	logic [NUM_W-1:0] next_tx_d, next_rx_d, last_d;
	logic [HFN_W-1:0] tx_hfn_d, rx_hfn_d;

	logic [LEN_W-1:0] len;
	logic [NUM_W-1:0] m, sn, sn_plus, tx_used;
	logic             sn_at_max, behind;
	logic [HFN_W-1:0] rxh_inc, rxh_inc2, rxh_dec, hfn_sel;
	logic [NUM_W-1:0] num_sel;
	logic [NUM_W:0]   sn_m_last, last_m_sn, next_m_sn, sn_m_next;
	logic [NUM_W-1:0] win;
	logic             am_discard, am_ahead, am_old;
	logic             keep_count;
	logic [NUM_W+HFN_W-1:0] shifted;
	logic             take;

	assign take     = cmd_valid && !res_full;
	assign cmd_pop  = take;
	assign res_push = take;

	assign len       = eff_len(cfg.sn_length);
	assign m         = num_mask(len);
	assign sn        = cmd_item.sn;
	assign sn_plus   = sn + NUM_W'(1);
	assign sn_at_max = (sn == m);
	assign behind    = (sn < next_rx_q);
	assign tx_used   = next_tx_q & m;
	assign rxh_inc   = rx_hfn_q + HFN_W'(1);
	assign rxh_inc2  = rx_hfn_q + HFN_W'(2);
	assign rxh_dec   = rx_hfn_q - HFN_W'(1);

	// Plain signed differences for the AM window rules
	assign win        = NUM_W'(cfg.reorder_window);
	assign sn_m_last  = {1'b0, sn} - {1'b0, last_q};
	assign last_m_sn  = {1'b0, last_q} - {1'b0, sn};
	assign next_m_sn  = {1'b0, next_rx_q} - {1'b0, sn};
	assign sn_m_next  = {1'b0, sn} - {1'b0, next_rx_q};
	assign am_discard = (!sn_m_last[NUM_W] && (sn_m_last[NUM_W-1:0] > win)) ||
	                    (!last_m_sn[NUM_W] && (last_m_sn[NUM_W-1:0] < win));
	assign am_ahead   = !next_m_sn[NUM_W] && (next_m_sn[NUM_W-1:0] > win);
	assign am_old     = !sn_m_next[NUM_W] && (sn_m_next[NUM_W-1:0] >= win);

	// Decide status, counter updates and the HFN / number that form COUNT
	always_comb begin
		next_tx_d  = next_tx_q;
		tx_hfn_d   = tx_hfn_q;
		next_rx_d  = next_rx_q;
		rx_hfn_d   = rx_hfn_q;
		last_d     = last_q;
		hfn_sel    = rx_hfn_q;
		num_sel    = sn;
		keep_count = 1'b0;
		res_item.status   = ST_REESTAB;
		res_item.used_num = '0;
		case (cmd_item.kind)
			K_TX_DROP: begin
				res_item.status = ST_TX_DROPPED;
			end
			K_TX_GIVEN: begin
				res_item.status   = ST_TX_ASSIGNED;
				res_item.used_num = sn;
				hfn_sel           = tx_hfn_q;
				keep_count        = 1'b1;
			end
			K_TX_NEXT: begin
				res_item.status   = ST_TX_ASSIGNED;
				res_item.used_num = tx_used;
				hfn_sel           = tx_hfn_q;
				num_sel           = tx_used;
				keep_count        = 1'b1;
				if (tx_used == m) begin
					next_tx_d = '0;
					tx_hfn_d  = tx_hfn_q + HFN_W'(1);
				end else begin
					next_tx_d = tx_used + NUM_W'(1);
				end
			end
			K_RX_CTRL: begin
				res_item.status = ST_CTRL_PASSED;
			end
			K_RX_SHORT: begin
				res_item.status = ST_RX_SHORT;
			end
			K_RX_SRB, K_RX_UM: begin
				res_item.used_num = sn;
				keep_count        = 1'b1;
				hfn_sel           = behind ? rxh_inc : rx_hfn_q;
				if (cmd_item.kind == K_RX_SRB && !cmd_item.integ_ok) begin
					res_item.status = ST_INTEG_FAIL;
				end else begin
					res_item.status = ST_RX_DELIVER;
					next_rx_d       = sn_at_max ? '0 : sn_plus;
					if (sn_at_max) begin
						rx_hfn_d = behind ? rxh_inc2 : rxh_inc;
					end else begin
						rx_hfn_d = behind ? rxh_inc : rx_hfn_q;
					end
				end
			end
			K_RX_AM: begin
				res_item.used_num = sn;
				if (am_discard) begin
					res_item.status = ST_RX_DISCARD;
				end else begin
					res_item.status = ST_RX_DELIVER;
					keep_count      = 1'b1;
					last_d          = sn;
					if (am_ahead) begin
						// Number from the next hyperframe
						hfn_sel   = rxh_inc;
						next_rx_d = sn_at_max ? '0 : sn_plus;
						rx_hfn_d  = sn_at_max ? rxh_inc2 : rxh_inc;
					end else if (am_old) begin
						// Number from the previous hyperframe
						hfn_sel = rxh_dec;
					end else if (!sn_m_next[NUM_W]) begin
						hfn_sel   = rx_hfn_q;
						next_rx_d = sn_at_max ? '0 : sn_plus;
						rx_hfn_d  = sn_at_max ? rxh_inc : rx_hfn_q;
					end else begin
						hfn_sel = rx_hfn_q;
					end
				end
			end
			K_REEST_CLR: begin
				res_item.status = ST_REESTAB;
				next_tx_d = '0;
				tx_hfn_d  = '0;
				next_rx_d = '0;
				rx_hfn_d  = '0;
			end
			K_REEST_KEEP: begin
				res_item.status = ST_REESTAB;
			end
			default: begin
				res_item.status = ST_REESTAB;
			end
		endcase

		// Form COUNT from the chosen HFN and number
		shifted = {{NUM_W{1'b0}}, hfn_sel} << len;
		res_item.count_value = keep_count ?
			(shifted[COUNT_W-1:0] | COUNT_W'(num_sel)) : '0;
	end

	// Hold bearer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_tx_q <= '0;
			tx_hfn_q  <= '0;
			next_rx_q <= '0;
			rx_hfn_q  <= '0;
			last_q    <= LAST_DELIV_RST;
		end else if (take) begin
			next_tx_q <= next_tx_d;
			tx_hfn_q  <= tx_hfn_d;
			next_rx_q <= next_rx_d;
			rx_hfn_q  <= rx_hfn_d;
			last_q    <= last_d;
		end
	end

endmodule

// ----- design/pdcp_count_sequence_tracker_unit.sv -----
// Top level of the PDCP COUNT / sequence tracker for one bearer.
// Depends on pdcp_cst_pkg, pdcp_cst_front, pdcp_cst_queue and pdcp_cst_back.
//
// Channel   Handshake                 Payload
// input     push / full               in_item  (opcode, seq_num, flags, pdu_bytes)
// result    empty / pop               out_item (status, count_value, used_num)
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One item per cycle sustained while the result queue has room; an item's result
// is poppable once it has passed the command queue, then the result queue.
// The back end's combinational COUNT estimate over the bearer counters sets the rate.
// Reset clears the counters, both queues and loads the register defaults.
// A full result queue stalls the back end; the command queue then fills and
// raises full. Configuration is always ready.
module pdcp_count_sequence_tracker_unit #(
	parameter int CMD_DEPTH = pdcp_cst_pkg::CMD_DEPTH_DEF,
	parameter int RES_DEPTH = pdcp_cst_pkg::RES_DEPTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	output logic                                    full,
	input  pdcp_cst_pkg::in_item_t                  in_item,
	output logic                                    empty,
	input  logic                                    pop,
	output pdcp_cst_pkg::out_item_t                 out_item,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic [pdcp_cst_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdcp_cst_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import pdcp_cst_pkg::*;

	localparam int CLS_W = $bits(cls_item_t);
	localparam int OUT_W = $bits(out_item_t);

	cfg_t      cfg_q;
	logic      cmd_push, cmd_full, cmd_empty, cmd_pop;
	cls_item_t cmd_wr, cmd_rd;
	logic      res_push, res_full;
	out_item_t res_wr;
	logic [CLS_W-1:0] cmd_rd_bits;
	logic [OUT_W-1:0] res_rd_bits;

	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sn_length      <= SN_LENGTH_RST;
			cfg_q.bearer_mode    <= BEARER_MODE_RST;
			cfg_q.reorder_window <= REORDER_WINDOW_RST;
			cfg_q.header_bytes   <= HEADER_BYTES_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SN_LENGTH:      cfg_q.sn_length      <= cfg_data[LEN_W-1:0];
				CFG_BEARER_MODE:    cfg_q.bearer_mode    <= cfg_data[1:0];
				CFG_REORDER_WINDOW: cfg_q.reorder_window <= cfg_data[WIN_W-1:0];
				CFG_HEADER_BYTES:   cfg_q.header_bytes   <= cfg_data[1:0];
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	pdcp_cst_front u_front (
		.cfg      (cfg_q),
		.push     (push),
		.in_item  (in_item),
		.full     (full),
		.cls_push (cmd_push),
		.cls_item (cmd_wr),
		.cls_full (cmd_full)
	);

	pdcp_cst_queue #(
		.WIDTH (CLS_W),
		.DEPTH (CMD_DEPTH)
	) u_cmd_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd_wr),
		.full   (cmd_full),
		.pop    (cmd_pop),
		.rdata  (cmd_rd_bits),
		.empty  (cmd_empty)
	);

	assign cmd_rd = cls_item_t'(cmd_rd_bits);

	pdcp_cst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (!cmd_empty),
		.cmd_item  (cmd_rd),
		.cmd_pop   (cmd_pop),
		.res_push  (res_push),
		.res_item  (res_wr),
		.res_full  (res_full)
	);

	pdcp_cst_queue #(
		.WIDTH (OUT_W),
		.DEPTH (RES_DEPTH)
	) u_res_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res_wr),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_rd_bits),
		.empty  (empty)
	);

	assign out_item = out_item_t'(res_rd_bits);

	// Every command taken by the back end yields exactly one result
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && !cmd_empty) == res_push)
		else $error("command consumed without a matching result");

	// Back end never pushes into a full result queue
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed while result queue full");

	// Unused opcode is never queued
	a_no_rsvd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> (in_item.opcode == OP_TX || in_item.opcode == OP_RX ||
		              in_item.opcode == OP_REEST))
		else $error("unused opcode entered the command queue");

	// A queued command shows the back end a pending item next cycle
	a_cmd_seen: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |=> !cmd_empty || $past(cmd_pop))
		else $error("queued command lost");

endmodule
